// ===== src/vrt_pkg.sv =====
// shared constants and types for the voxel ray traversal block
`timescale 1ns / 1ps
package vrt_pkg;

  localparam int GRID_SIDE_BITS = 5;
  localparam int MAX_STEPS      = 1024;

  localparam int CELL_AW   = 3 * GRID_SIDE_BITS;
  localparam int STEP_W    = $clog2(MAX_STEPS);
  localparam int POS_W     = $clog2(128 + MAX_STEPS) + 1;
  localparam int N_W       = 16 + $clog2(MAX_STEPS + 2);
  localparam int PROD_W    = N_W + 16;
  localparam int MUL_W     = 32;
  localparam int ACC_W     = 80;
  localparam int ONE_VOXEL = 65536;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_FETCH,
    ST_TEST,
    ST_BEYOND,
    ST_CHOOSE,
    ST_ADVANCE
  } state_e;

endpackage

// ===== src/vrt_grid_mem.sv =====
// occupancy bitmap memory, one write port and one registered read port
`timescale 1ns / 1ps
module vrt_grid_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [vrt_pkg::CELL_AW-1:0] waddr_i,
  input  logic                       wdata_i,
  input  logic [vrt_pkg::CELL_AW-1:0] raddr_i,
  output logic                       rdata_o
);

  logic mem [(2**vrt_pkg::CELL_AW)-1:0];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/voxel_ray_traversal.sv =====
// voxel ray traversal: occupancy grid plus three-axis dda ray caster
//
// an item is taken when start_i is high and busy_o is low. op 0 writes one
// grid cell, op 1 casts a ray. every item gives exactly one result, shown on
// the result ports for one cycle while done_o is high; the receiver always
// takes it.
// a write gives its all-zero result in the cycle after it is taken. a cast
// with zero direction does the same. a cast otherwise runs a setup phase,
// then per voxel step a grid read and test, the choice of the nearest
// boundary (six products on the one shared 32x32 multiplier), an advance,
// plus a distance check once a boundary has been crossed; up to MAX_STEPS
// steps are taken. busy_o stays high for the whole cast.
// after reset the grid is cleared one cell a cycle, all 2^(3*GRID_SIDE_BITS)
// cells, 32768 by default; busy_o is high during that sweep.
`timescale 1ns / 1ps
module voxel_ray_traversal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic signed [23:0] origin_x_i,
  input  logic signed [23:0] origin_y_i,
  input  logic signed [23:0] origin_z_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic        [23:0] max_distance_i,
  input  logic        [14:0] cell_index_i,
  input  logic               cell_opaque_i,
  output logic               done_o,
  output logic               hit_o,
  output logic signed [7:0]  block_x_o,
  output logic signed [7:0]  block_y_o,
  output logic signed [7:0]  block_z_o,
  output logic signed [1:0]  normal_x_o,
  output logic signed [1:0]  normal_y_o,
  output logic signed [1:0]  normal_z_o
);

  localparam int B  = vrt_pkg::GRID_SIDE_BITS;
  localparam int AW = vrt_pkg::CELL_AW;
  localparam int PW = vrt_pkg::POS_W;
  localparam int NW = vrt_pkg::N_W;
  localparam int QW = vrt_pkg::PROD_W;
  localparam int MW = vrt_pkg::MUL_W;
  localparam int CW = vrt_pkg::ACC_W;
  localparam int SW = vrt_pkg::STEP_W;

  vrt_pkg::state_e state_q, state_d;

  logic [AW-1:0]  clr_cnt_q;
  logic [2:0]     uop_q;
  logic [SW-1:0]  step_cnt_q;

  logic signed [PW-1:0] p_q   [3];
  logic signed [1:0]    stp_q [3];
  logic signed [1:0]    nrm_q [3];
  logic [15:0]          a_q   [3];
  logic [NW-1:0]        n_q   [3];
  logic [30:0]          asq_q [3];
  logic [QW-1:0]        prod_q [6];
  logic [23:0]          m_q;
  logic [47:0]          msq_q;
  logic [31:0]          dd_q;
  logic [NW-1:0]        tn_q;
  logic                 ta_nz_q;
  logic [30:0]          tasq_q;
  logic [47:0]          sq_q;
  logic [CW-1:0]        lhs_q, rhs_q;

  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] mul_q;

  logic            mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0]   mem_waddr, mem_raddr;

  logic            take, take_write, take_cast, dir_zero, in_grid, cell_ok;
  logic            finish, fin_hit, beyond_now, le01, le02, le12;
  logic [1:0]      k_sel;

  logic            done_q, hit_q;
  logic [7:0]      blk_q [3];
  logic [1:0]      nrmo_q [3];

  logic signed [23:0] org [3];
  logic signed [15:0] dir [3];

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  assign busy_o     = (state_q != vrt_pkg::ST_IDLE);
  assign take       = start_i && !busy_o;
  assign take_write = take && (op_i == vrt_pkg::OP_WRITE);
  assign dir_zero   = (dir_x_i == 16'sd0) && (dir_y_i == 16'sd0) && (dir_z_i == 16'sd0);
  assign take_cast  = take && (op_i == vrt_pkg::OP_CAST) && !dir_zero;

  // writes past the grid are dropped
  assign cell_ok = ((32'(cell_index_i) >> AW) == 32'd0);

  always_comb begin
    in_grid = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (p_q[i][PW-1] || (p_q[i][PW-2:B] != '0)) in_grid = 1'b0;
    end
  end

  assign beyond_now = (lhs_q > rhs_q);

  // boundary compare by cross products, zero direction is infinitely far
  assign le01 = (a_q[1] == 16'd0) || ((a_q[0] != 16'd0) && (prod_q[0] <= prod_q[1]));
  assign le02 = (a_q[2] == 16'd0) || ((a_q[0] != 16'd0) && (prod_q[2] <= prod_q[3]));
  assign le12 = (a_q[2] == 16'd0) || ((a_q[1] != 16'd0) && (prod_q[4] <= prod_q[5]));

  always_comb begin
    priority if (le01 && le02) k_sel = 2'd0;
    else if (le12)             k_sel = 2'd1;
    else                       k_sel = 2'd2;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vrt_pkg::ST_CLEAR: if (clr_cnt_q == '1) state_d = vrt_pkg::ST_IDLE;
      vrt_pkg::ST_IDLE: if (take_cast) state_d = vrt_pkg::ST_SETUP;
      vrt_pkg::ST_SETUP: if (uop_q == 3'd4) state_d = vrt_pkg::ST_FETCH;
      vrt_pkg::ST_FETCH: state_d = vrt_pkg::ST_TEST;
      vrt_pkg::ST_TEST: begin
        priority if (in_grid && mem_rdata) state_d = vrt_pkg::ST_IDLE;
        else if (ta_nz_q && (32'(tn_q) > 32'(m_q))) state_d = vrt_pkg::ST_IDLE;
        else if (ta_nz_q) state_d = vrt_pkg::ST_BEYOND;
        else state_d = vrt_pkg::ST_CHOOSE;
      end
      vrt_pkg::ST_BEYOND: begin
        if (uop_q == 3'd7) begin
          state_d = beyond_now ? vrt_pkg::ST_IDLE : vrt_pkg::ST_CHOOSE;
        end
      end
      vrt_pkg::ST_CHOOSE: if (uop_q == 3'd6) state_d = vrt_pkg::ST_ADVANCE;
      vrt_pkg::ST_ADVANCE: begin
        state_d = (step_cnt_q == SW'(vrt_pkg::MAX_STEPS - 1)) ? vrt_pkg::ST_IDLE
                                                               : vrt_pkg::ST_FETCH;
      end
      default: state_d = vrt_pkg::ST_IDLE;
    endcase
  end

  // control outputs: multiplier operands, memory port, completion
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mem_we    = 1'b0;
    mem_waddr = AW'(cell_index_i);
    mem_wdata = cell_opaque_i;
    mem_raddr = {p_q[2][B-1:0], p_q[1][B-1:0], p_q[0][B-1:0]};
    finish    = 1'b0;
    fin_hit   = 1'b0;
    unique case (state_q)
      vrt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = 1'b0;
      end
      vrt_pkg::ST_IDLE: begin
        mem_we = take_write && cell_ok;
        finish = take_write || (take && (op_i == vrt_pkg::OP_CAST) && dir_zero);
      end
      vrt_pkg::ST_SETUP: begin
        unique case (uop_q)
          3'd0: begin mul_a = MW'(a_q[0]); mul_b = MW'(a_q[0]); end
          3'd1: begin mul_a = MW'(a_q[1]); mul_b = MW'(a_q[1]); end
          3'd2: begin mul_a = MW'(a_q[2]); mul_b = MW'(a_q[2]); end
          3'd3: begin mul_a = MW'(m_q);    mul_b = MW'(m_q);    end
          default: ;
        endcase
      end
      vrt_pkg::ST_FETCH: ;
      vrt_pkg::ST_TEST: begin
        if (in_grid && mem_rdata) begin
          finish  = 1'b1;
          fin_hit = 1'b1;
        end else if (ta_nz_q && (32'(tn_q) > 32'(m_q))) begin
          finish = 1'b1;
        end
      end
      vrt_pkg::ST_BEYOND: begin
        unique case (uop_q)
          3'd0: begin mul_a = MW'(tn_q[23:0]);   mul_b = MW'(tn_q[23:0]); end
          3'd2: begin mul_a = MW'(sq_q[23:0]);   mul_b = dd_q; end
          3'd3: begin mul_a = MW'(sq_q[47:24]);  mul_b = dd_q; end
          3'd4: begin mul_a = MW'(msq_q[23:0]);  mul_b = MW'(tasq_q); end
          3'd5: begin mul_a = MW'(msq_q[47:24]); mul_b = MW'(tasq_q); end
          3'd7: finish = beyond_now;
          default: ;
        endcase
      end
      vrt_pkg::ST_CHOOSE: begin
        unique case (uop_q)
          3'd0: begin mul_a = MW'(n_q[0]); mul_b = MW'(a_q[1]); end
          3'd1: begin mul_a = MW'(n_q[1]); mul_b = MW'(a_q[0]); end
          3'd2: begin mul_a = MW'(n_q[0]); mul_b = MW'(a_q[2]); end
          3'd3: begin mul_a = MW'(n_q[2]); mul_b = MW'(a_q[0]); end
          3'd4: begin mul_a = MW'(n_q[1]); mul_b = MW'(a_q[2]); end
          3'd5: begin mul_a = MW'(n_q[2]); mul_b = MW'(a_q[1]); end
          default: ;
        endcase
      end
      vrt_pkg::ST_ADVANCE: finish = (step_cnt_q == SW'(vrt_pkg::MAX_STEPS - 1));
      default: ;
    endcase
  end

  vrt_grid_mem u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    mul_q <= (2*MW)'(mul_a) * (2*MW)'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= vrt_pkg::ST_CLEAR;
      clr_cnt_q  <= '0;
      uop_q      <= '0;
      step_cnt_q <= '0;
      ta_nz_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= finish;
      if (state_q == vrt_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (state_d != state_q) uop_q <= '0;
      else                    uop_q <= uop_q + 1'b1;
      if (take_cast) begin
        step_cnt_q <= '0;
        ta_nz_q    <= 1'b0;
      end else if (state_q == vrt_pkg::ST_ADVANCE) begin
        step_cnt_q <= step_cnt_q + 1'b1;
        ta_nz_q    <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (take_cast) begin
      m_q <= max_distance_i;
      for (int i = 0; i < 3; i++) begin
        p_q[i]   <= PW'($signed(org[i][23:16]));
        nrm_q[i] <= 2'sd0;
        if (dir[i] > 16'sd0) begin
          stp_q[i] <= 2'sd1;
          n_q[i]   <= NW'(vrt_pkg::ONE_VOXEL) - NW'(org[i][15:0]);
        end else begin
          stp_q[i] <= (dir[i] < 16'sd0) ? -2'sd1 : 2'sd0;
          n_q[i]   <= NW'(org[i][15:0]);
        end
        a_q[i] <= dir[i][15] ? 16'(~dir[i] + 16'sd1) : 16'(dir[i]);
      end
    end
    unique case (state_q)
      vrt_pkg::ST_SETUP: begin
        unique case (uop_q)
          3'd1: asq_q[0] <= mul_q[30:0];
          3'd2: asq_q[1] <= mul_q[30:0];
          3'd3: asq_q[2] <= mul_q[30:0];
          3'd4: begin
            msq_q <= mul_q[47:0];
            dd_q  <= 32'(asq_q[0]) + 32'(asq_q[1]) + 32'(asq_q[2]);
          end
          default: ;
        endcase
      end
      vrt_pkg::ST_BEYOND: begin
        // n^2 * dd against m^2 * a^2, each in two partial products
        unique case (uop_q)
          3'd1: sq_q  <= mul_q[47:0];
          3'd3: lhs_q <= CW'(mul_q);
          3'd4: lhs_q <= lhs_q + (CW'(mul_q) << 24);
          3'd5: rhs_q <= CW'(mul_q);
          3'd6: rhs_q <= rhs_q + (CW'(mul_q) << 24);
          default: ;
        endcase
      end
      vrt_pkg::ST_CHOOSE: begin
        unique case (uop_q)
          3'd1: prod_q[0] <= mul_q[QW-1:0];
          3'd2: prod_q[1] <= mul_q[QW-1:0];
          3'd3: prod_q[2] <= mul_q[QW-1:0];
          3'd4: prod_q[3] <= mul_q[QW-1:0];
          3'd5: prod_q[4] <= mul_q[QW-1:0];
          3'd6: prod_q[5] <= mul_q[QW-1:0];
          default: ;
        endcase
      end
      vrt_pkg::ST_ADVANCE: begin
        for (int i = 0; i < 3; i++) begin
          if (k_sel == 2'(i)) begin
            p_q[i]   <= p_q[i] + PW'(stp_q[i]);
            tn_q     <= n_q[i];
            tasq_q   <= asq_q[i];
            n_q[i]   <= n_q[i] + NW'(vrt_pkg::ONE_VOXEL);
            nrm_q[i] <= -stp_q[i];
          end else begin
            nrm_q[i] <= 2'sd0;
          end
        end
      end
      default: ;
    endcase
    if (finish) begin
      hit_q <= fin_hit;
      for (int i = 0; i < 3; i++) begin
        blk_q[i]  <= fin_hit ? p_q[i][7:0] : 8'd0;
        nrmo_q[i] <= fin_hit ? nrm_q[i] : 2'sd0;
      end
    end
  end

  assign done_o     = done_q;
  assign hit_o      = hit_q;
  assign block_x_o  = blk_q[0];
  assign block_y_o  = blk_q[1];
  assign block_z_o  = blk_q[2];
  assign normal_x_o = nrmo_q[0];
  assign normal_y_o = nrmo_q[1];
  assign normal_z_o = nrmo_q[2];

endmodule

// ===== tb/voxel_ray_traversal_test.sv =====
// self-checking testbench for the voxel ray traversal block
`timescale 1ns / 1ps
module voxel_ray_traversal_test;

  localparam int SIDE  = 1 << vrt_pkg::GRID_SIDE_BITS;
  localparam int CELLS = 1 << vrt_pkg::CELL_AW;

  typedef struct packed {
    logic              hit;
    logic signed [7:0] block_x;
    logic signed [7:0] block_y;
    logic signed [7:0] block_z;
    logic signed [1:0] normal_x;
    logic signed [1:0] normal_y;
    logic signed [1:0] normal_z;
  } ray_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               op_i = vrt_pkg::OP_WRITE;
  logic signed [23:0] origin_x_i = '0;
  logic signed [23:0] origin_y_i = '0;
  logic signed [23:0] origin_z_i = '0;
  logic signed [15:0] dir_x_i = '0;
  logic signed [15:0] dir_y_i = '0;
  logic signed [15:0] dir_z_i = '0;
  logic        [23:0] max_distance_i = '0;
  logic        [14:0] cell_index_i = '0;
  logic               cell_opaque_i = 1'b0;
  logic               done_o;
  logic               hit_o;
  logic signed [7:0]  block_x_o, block_y_o, block_z_o;
  logic signed [1:0]  normal_x_o, normal_y_o, normal_z_o;

  voxel_ray_traversal u_top (.*);

  always #4 clk_i = ~clk_i;

  bit          occupancy[CELLS];
  ray_result_t pending_results[$];
  int          error_count = 0;
  bit          idle_enable = 1'b1;

  function automatic bit opaque_at(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= SIDE || y >= SIDE || z >= SIDE) return 1'b0;
    return occupancy[(z << (2 * vrt_pkg::GRID_SIDE_BITS)) | (y << vrt_pkg::GRID_SIDE_BITS) | x];
  endfunction

  // ni/ai <= nj/aj with a zero slope meaning never
  function automatic bit boundary_le(longint unsigned ni, longint unsigned ai,
                                     longint unsigned nj, longint unsigned aj);
    if (aj == 0) return 1'b1;
    if (ai == 0) return 1'b0;
    return ni * aj <= nj * ai;
  endfunction

  // n/a * |d| > m, squared on both sides
  function automatic bit past_limit(longint unsigned n, longint unsigned a,
                                    longint unsigned dd, longint unsigned m);
    logic [127:0] lhs, rhs;
    if (n > m) return 1'b1;
    lhs = 128'(n * n) * 128'(dd);
    rhs = 128'(m * m) * 128'(a * a);
    return lhs > rhs;
  endfunction

  function automatic ray_result_t trace_ray(logic signed [23:0] ox, logic signed [23:0] oy,
                                            logic signed [23:0] oz, logic signed [15:0] dx,
                                            logic signed [15:0] dy, logic signed [15:0] dz,
                                            logic [23:0] max_dist);
    ray_result_t       r;
    logic signed [23:0] org[3];
    logic signed [15:0] dir[3];
    int                pos[3], stp[3], nrm[3];
    longint unsigned   a[3], nb[3], dd, tn, ta, m;
    int                k;
    bit                hit;
    r = '0;
    org[0] = ox; org[1] = oy; org[2] = oz;
    dir[0] = dx; dir[1] = dy; dir[2] = dz;
    dd = 0; tn = 0; ta = 0; hit = 1'b0; m = 64'(max_dist);
    for (int j = 0; j < 3; j++) begin
      pos[j] = int'(org[j] >>> 16);
      stp[j] = dir[j] > 0 ? 1 : (dir[j] < 0 ? -1 : 0);
      a[j]   = dir[j] < 0 ? longint'(-int'(dir[j])) : longint'(dir[j]);
      dd    += a[j] * a[j];
      nb[j]  = stp[j] > 0 ? 64'(vrt_pkg::ONE_VOXEL - int'(org[j][15:0]))
                          : 64'(org[j][15:0]);
      nrm[j] = 0;
    end
    if (dd == 0) return r;
    for (int i = 0; i < vrt_pkg::MAX_STEPS; i++) begin
      if (opaque_at(pos[0], pos[1], pos[2])) begin
        hit = 1'b1;
        break;
      end
      if (ta != 0 && past_limit(tn, ta, dd, m)) break;
      if (boundary_le(nb[0], a[0], nb[1], a[1]) &&
          boundary_le(nb[0], a[0], nb[2], a[2])) k = 0;
      else if (boundary_le(nb[1], a[1], nb[2], a[2])) k = 1;
      else k = 2;
      pos[k] += stp[k];
      tn = nb[k];
      ta = a[k];
      nb[k] += 64'(vrt_pkg::ONE_VOXEL);
      nrm[0] = 0; nrm[1] = 0; nrm[2] = 0;
      nrm[k] = -stp[k];
    end
    if (hit) begin
      r.hit = 1'b1;
      r.block_x = pos[0][7:0]; r.block_y = pos[1][7:0]; r.block_z = pos[2][7:0];
      r.normal_x = nrm[0][1:0]; r.normal_y = nrm[1][1:0]; r.normal_z = nrm[2][1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, ray_result_t want, ray_result_t got);
    $display({"mismatch %s: want %0d (%0d,%0d,%0d) n(%0d,%0d,%0d)",
              " got %0d (%0d,%0d,%0d) n(%0d,%0d,%0d)"},
             what, want.hit, want.block_x, want.block_y, want.block_z,
             want.normal_x, want.normal_y, want.normal_z, got.hit, got.block_x,
             got.block_y, got.block_z, got.normal_x, got.normal_y, got.normal_z);
    error_count++;
  endtask

  // present one item, hold it until taken, then predict its result
  task automatic send_item(logic op, logic signed [23:0] ox, logic signed [23:0] oy,
                           logic signed [23:0] oz, logic signed [15:0] dx,
                           logic signed [15:0] dy, logic signed [15:0] dz,
                           logic [23:0] md, logic [14:0] idx, logic opq);
    if (idle_enable && $urandom_range(99) < 18) begin
      start_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    origin_x_i <= ox; origin_y_i <= oy; origin_z_i <= oz;
    dir_x_i <= dx; dir_y_i <= dy; dir_z_i <= dz;
    max_distance_i <= md; cell_index_i <= idx; cell_opaque_i <= opq;
    do @(posedge clk_i); while (busy_o);
    if (op == vrt_pkg::OP_WRITE) begin
      if (idx < CELLS) occupancy[idx] = opq;
      pending_results.push_back('0);
    end else begin
      pending_results.push_back(trace_ray(ox, oy, oz, dx, dy, dz, md));
    end
  endtask

  task automatic write_cell(int x, int y, int z, logic opq);
    send_item(vrt_pkg::OP_WRITE, 24'($urandom), 24'($urandom), 24'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
              15'((z << (2 * vrt_pkg::GRID_SIDE_BITS)) | (y << vrt_pkg::GRID_SIDE_BITS) | x),
              opq);
  endtask

  function automatic logic signed [23:0] vox(int v, int frac);
    return 24'((v << 16) + frac);
  endfunction

  always @(posedge clk_i) begin
    ray_result_t got, want;
    if (done_o) begin
      got = {hit_o, block_x_o, block_y_o, block_z_o, normal_x_o, normal_y_o, normal_z_o};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit || got.block_x !== want.block_x ||
            got.block_y !== want.block_y || got.block_z !== want.block_z ||
            got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
            got.normal_z !== want.normal_z)
          report_mismatch("result", want, got);
      end
    end
  end

  task automatic test_directed_writes();
    write_cell(0, 0, 0, 1'b1);
    write_cell(SIDE - 1, SIDE - 1, SIDE - 1, 1'b1);
    write_cell(10, 5, 5, 1'b1);
    write_cell(5, 5, 20, 1'b1);
    write_cell(SIDE - 1, SIDE - 1, SIDE - 1, 1'b0);
    send_item(vrt_pkg::OP_WRITE, '0, '0, '0, '0, '0, '0, '0, 15'h7fff, 1'b1);
    send_item(vrt_pkg::OP_WRITE, '1, '1, '1, '1, '1, '1, '1, 15'h7fff, 1'b0);
  endtask

  task automatic test_directed_casts();
    // origin cell opaque
    send_item(vrt_pkg::OP_CAST, vox(0, 16'h8000), vox(0, 1), vox(0, 16'hffff), 16'sd100,
              '0, '0, 24'hffffff, '0, 1'b0);
    // zero direction
    send_item(vrt_pkg::OP_CAST, vox(5, 0), vox(5, 0), vox(5, 0), '0, '0, '0, 24'hffffff,
              '0, 1'b0);
    // straight along x in both signs and along +z, then a negative diagonal
    send_item(vrt_pkg::OP_CAST, vox(2, 16'h8000), vox(5, 16'h8000), vox(5, 16'h8000),
              16'sd32767, '0, '0, vox(20, 0), '0, 1'b0);
    send_item(vrt_pkg::OP_CAST, vox(20, 16'h8000), vox(5, 16'h8000), vox(5, 16'h8000),
              -16'sd32768, '0, '0, vox(20, 0), '0, 1'b0);
    send_item(vrt_pkg::OP_CAST, vox(5, 16'h8000), vox(5, 16'h8000), vox(2, 16'h8000),
              '0, '0, 16'sd1, vox(30, 0), '0, 1'b0);
    send_item(vrt_pkg::OP_CAST, vox(3, 16'h8000), vox(3, 16'h8000), vox(3, 16'h8000),
              -16'sd7, -16'sd7, -16'sd7, vox(10, 0), '0, 1'b0);
    // exact diagonal ties
    send_item(vrt_pkg::OP_CAST, vox(8, 0), vox(3, 0), vox(3, 0), 16'sd4096, 16'sd4096,
              16'sd4096, vox(40, 0), '0, 1'b0);
    send_item(vrt_pkg::OP_CAST, vox(9, 0), vox(4, 0), vox(5, 0), 16'sd3, 16'sd3, '0,
              vox(40, 0), '0, 1'b0);
    // distance too short, and zero distance
    send_item(vrt_pkg::OP_CAST, vox(2, 16'h8000), vox(5, 16'h8000), vox(5, 16'h8000),
              16'sd1, '0, '0, vox(3, 0), '0, 1'b0);
    send_item(vrt_pkg::OP_CAST, vox(9, 16'h8000), vox(5, 16'h8000), vox(5, 16'h8000),
              16'sd1, '0, '0, 24'd0, '0, 1'b0);
    // origin far outside the grid, stopped by the distance limit
    send_item(vrt_pkg::OP_CAST, 24'sh800000, 24'sh7fffff, 24'sh800000, 16'sd1, -16'sd1,
              16'sd1, 24'hffffff, '0, 1'b0);
    // from outside, entering the grid
    send_item(vrt_pkg::OP_CAST, vox(-3, 16'h4000), vox(0, 16'h8000), vox(0, 16'h8000),
              16'sd500, '0, '0, vox(10, 0), '0, 1'b0);
  endtask

  task automatic test_random();
    int casts;
    // scatter opaque cells so most rays end early
    for (int i = 0; i < 140; i++)
      write_cell($urandom_range(SIDE - 1), $urandom_range(SIDE - 1),
                 $urandom_range(SIDE - 1), 1'b1);
    for (int i = 0; i < 380; i++) begin
      if (i == 150) idle_enable = 1'b0;
      if (i == 230) idle_enable = 1'b1;
      casts = $urandom_range(99);
      if (casts < 20) begin
        send_item(vrt_pkg::OP_WRITE, 24'($urandom), 24'($urandom), 24'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                  15'($urandom), $urandom_range(3) != 0);
      end else if (casts < 26) begin
        // fully random fields, half of them with a short limit to bound run time
        send_item(vrt_pkg::OP_CAST, 24'($urandom), 24'($urandom), 24'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom),
                  casts < 23 ? 24'($urandom) : 24'($urandom_range(24'h1fffff)), '0, 1'b0);
      end else begin
        send_item(vrt_pkg::OP_CAST,
                  vox(int'($urandom_range(SIDE + 1)) - 1, int'($urandom_range(16'hffff))),
                  vox(int'($urandom_range(SIDE + 1)) - 1, int'($urandom_range(16'hffff))),
                  vox(int'($urandom_range(SIDE + 1)) - 1, int'($urandom_range(16'hffff))),
                  16'($urandom), 16'($urandom), 16'($urandom),
                  24'($urandom_range(24'h28ffff)), 15'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_writes();
    test_directed_casts();
    test_random();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #400ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
